FILE: design/kfpi_pkg.sv
package kfpi_pkg;
    localparam int Entries   = 64;
    localparam int IdxBits   = $clog2(Entries);
    localparam int CntBits   = $clog2(Entries + 1);
    localparam int TimeBits  = 32;
    localparam int CoordBits = 32;
    localparam int FracBits  = 24;
    // one memory word holds key and the three coordinates
    localparam int WordBits  = TimeBits + 3 * CoordBits;
    localparam int DivStepBits  = $clog2(FracBits + 1);
    localparam int LerpProdBits = CoordBits + 1 + FracBits;

    typedef enum logic [1:0] {
        KIND_CLEAR = 2'd0,
        KIND_ADD   = 2'd1,
        KIND_QUERY = 2'd2,
        KIND_SPARE = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_STORED   = 3'd0,
        ST_REPLACED = 3'd1,
        ST_FULL     = 3'd2,
        ST_CLEARED  = 3'd3,
        ST_EMPTY    = 3'd4,
        ST_BEFORE   = 3'd5,
        ST_AFTER    = 3'd6,
        ST_INTERP   = 3'd7
    } t_status;

    function automatic logic [TimeBits-1:0] word_key(input logic [WordBits-1:0] w);
        return w[TimeBits-1:0];
    endfunction

    function automatic logic signed [CoordBits-1:0] word_crd(input logic [WordBits-1:0] w,
                                                           input logic [1:0] k);
        logic signed [CoordBits-1:0] c;
        case (k)
            2'd0:    c = w[TimeBits +: CoordBits];
            2'd1:    c = w[TimeBits + CoordBits +: CoordBits];
            default: c = w[TimeBits + 2 * CoordBits +: CoordBits];
        endcase
        return c;
    endfunction
endpackage

FILE: design/keyframe_position_interpolator_core.sv
// an add searches for the first key not below t and shifts the tail up one slot;
// a query steps through the keys in the bracket search, then divides and lerps
// throughput: one request at a time, taken again once the result has been accepted
// i_rst_n synchronous active low empties the table; memory contents are not cleared
module keyframe_position_interpolator_core import kfpi_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,  // timestamp, in_x, in_y, in_z
    input  logic [1:0]   s_axis_tuser,  // kind
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [95:0]  m_axis_tdata,  // out_x, out_y, out_z
    output logic [2:0]   m_axis_tuser   // status
);
    typedef enum logic [11:0] {
        S_IDLE  = 12'b000000000001,
        S_SRCH  = 12'b000000000010,
        S_SWAIT = 12'b000000000100,
        S_SHIFT = 12'b000000001000,
        S_SHWR  = 12'b000000010000,
        S_LOW   = 12'b000000100000,
        S_LWAIT = 12'b000001000000,
        S_DIV   = 12'b000010000000,
        S_LERP  = 12'b000100000000,
        S_OUT   = 12'b001000000000,
        S_HIGH  = 12'b010000000000,
        S_HWAIT = 12'b100000000000
    } t_state;

    t_state                r_state;
    logic [CntBits-1:0]    r_cnt;
    logic [CntBits-1:0]    r_idx;
    logic [CntBits-1:0]    r_ptr;
    t_kind                 r_kind;
    logic [TimeBits-1:0]   r_t;
    logic [3*CoordBits-1:0] r_pos;
    logic [WordBits-1:0]   r_lo, r_hi;
    logic [95:0]           r_odata;
    logic [2:0]            r_ostat;
    logic                  r_ovalid;
    logic [2:0]            r_lcnt;
    logic [CoordBits-1:0]  r_lres [3];

    logic                  w_we;
    logic [IdxBits-1:0]    w_waddr, w_raddr;
    logic [WordBits-1:0]   w_wdata, w_rdata;
    logic                  w_div_start, w_div_done;
    logic [FracBits-1:0]   w_frac;
    logic [1:0]            w_lsel;
    logic [CoordBits-1:0]  w_lres;
    logic [TimeBits-1:0]   w_rkey;

    assign w_rkey = word_key(w_rdata);

    kfpi_ram #(.WIDTH(WordBits), .DEPTH(Entries)) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    // upper key is still on the read port when the divide starts
    kfpi_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_div_start),
        .i_num  (r_t - word_key(r_lo)),
        .i_den  (w_rkey - word_key(r_lo)),
        .o_done (w_div_done),
        .o_frac (w_frac)
    );

    assign w_lsel = r_lcnt[1:0];

    kfpi_lerp u_lerp (
        .i_clk (i_clk),
        .i_a   (word_crd(r_lo, w_lsel)),
        .i_b   (word_crd(r_hi, w_lsel)),
        .i_frac(w_frac),
        .o_res (w_lres)
    );

    assign s_axis_tready = (r_state == S_IDLE) && !r_ovalid;
    assign w_div_start   = (r_state == S_HWAIT) && (w_rkey != r_t);

    // memory address and write control
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_idx[IdxBits-1:0];
        w_wdata = {r_pos, r_t};
        w_raddr = r_idx[IdxBits-1:0];
        case (r_state)
            S_SHIFT: begin
                if (r_ptr == r_idx) begin
                    w_we = 1'b1;
                end else begin
                    w_raddr = IdxBits'(r_ptr - 1'b1);
                end
            end
            S_SHWR: begin
                w_we    = 1'b1;
                w_waddr = r_ptr[IdxBits-1:0];
                w_wdata = w_rdata;
            end
            S_HIGH: w_raddr = IdxBits'(r_idx + 1'b1);
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_kind  <= t_kind'(s_axis_tuser);
                        r_t     <= s_axis_tdata[31:0];
                        r_pos   <= s_axis_tdata[127:32];
                        r_idx   <= '0;
                        r_odata <= '0;
                        if (t_kind'(s_axis_tuser) == KIND_CLEAR) begin
                            r_cnt   <= '0;
                            r_ostat <= ST_CLEARED;
                            r_state <= S_OUT;
                        end else if (r_cnt == '0) begin
                            if (t_kind'(s_axis_tuser) == KIND_ADD) begin
                                r_ptr   <= '0;
                                r_ostat <= ST_STORED;
                                r_state <= S_SHIFT;
                            end else begin
                                r_ostat <= ST_EMPTY;
                                r_state <= S_OUT;
                            end
                        end else if (t_kind'(s_axis_tuser) == KIND_ADD) begin
                            r_state <= S_SRCH;
                        end else begin
                            r_state <= S_LOW;
                        end
                    end
                end
                // add: find first key not below t
                S_SRCH: r_state <= S_SWAIT;
                S_SWAIT: begin
                    if (w_rkey == r_t) begin
                        r_ostat <= ST_REPLACED;
                        r_ptr   <= r_idx;
                        r_state <= S_SHIFT;
                    end else if (w_rkey > r_t || r_idx == r_cnt - 1'b1) begin
                        if (r_cnt == CntBits'(Entries)) begin
                            r_ostat <= ST_FULL;
                            r_state <= S_OUT;
                        end else begin
                            r_ostat <= ST_STORED;
                            if (w_rkey < r_t) begin
                                r_idx <= r_idx + 1'b1;
                            end
                            r_ptr   <= r_cnt;
                            r_state <= S_SHIFT;
                        end
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_SRCH;
                    end
                end
                // shift tail up one slot, from the top down, then write the new entry
                S_SHIFT: begin
                    if (r_ptr == r_idx) begin
                        if (r_ostat == ST_STORED) begin
                            r_cnt <= r_cnt + 1'b1;
                        end
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_SHWR;
                    end
                end
                S_SHWR: begin
                    r_ptr   <= r_ptr - 1'b1;
                    r_state <= S_SHIFT;
                end
                S_LOW: r_state <= S_LWAIT;
                S_LWAIT: begin
                    r_lo <= w_rdata;
                    if (r_idx == '0 && r_t <= w_rkey) begin
                        r_odata <= w_rdata[TimeBits +: 96];
                        r_ostat <= ST_BEFORE;
                        r_state <= S_OUT;
                    end else if (r_idx == r_cnt - 1'b1) begin
                        r_odata <= w_rdata[TimeBits +: 96];
                        r_ostat <= ST_AFTER;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_HIGH;
                    end
                end
                S_HIGH: r_state <= S_HWAIT;
                S_HWAIT: begin
                    r_hi <= w_rdata;
                    if (w_rkey < r_t) begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_LOW;
                    end else if (w_rkey == r_t) begin
                        r_odata <= w_rdata[TimeBits +: 96];
                        r_ostat <= ST_INTERP;
                        r_state <= S_OUT;
                    end else begin
                        r_ostat <= ST_INTERP;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_lcnt  <= '0;
                        r_state <= S_LERP;
                    end
                end
                // feed one axis per cycle, collect each result once it leaves the lerp pipeline
                S_LERP: begin
                    r_lcnt <= r_lcnt + 1'b1;
                    if (r_lcnt >= 3'd3) begin
                        r_lres[r_lcnt[1:0] + 2'd1] <= w_lres;
                    end
                    if (r_lcnt == 3'd5) begin
                        r_odata <= {w_lres, r_lres[1], r_lres[0]};
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    r_ovalid <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ostat;
endmodule

FILE: design/kfpi_ram.sv
module kfpi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: design/kfpi_div.sv
module kfpi_div import kfpi_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [TimeBits-1:0] i_num,
    input  logic [TimeBits-1:0] i_den,
    output logic                o_done,
    output logic [FracBits-1:0] o_frac
);
    logic [TimeBits-1:0]    r_rem, n_rem;
    logic [TimeBits-1:0]    r_den;
    logic [FracBits-1:0]    r_frac, n_frac;
    logic [DivStepBits-1:0] r_step;
    logic                   r_busy, r_done;
    logic [TimeBits:0]      w_sh;

    // one restoring step per cycle
    always_comb begin
        w_sh   = {r_rem, 1'b0};
        n_rem  = w_sh[TimeBits-1:0];
        n_frac = {r_frac[FracBits-2:0], 1'b0};
        if (w_sh >= {1'b0, r_den}) begin
            n_rem  = TimeBits'(w_sh - {1'b0, r_den});
            n_frac[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == DivStepBits'(FracBits - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_num;
            r_den  <= i_den;
            r_frac <= '0;
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_frac <= n_frac;
        end
    end

    assign o_done = r_done;
    assign o_frac = r_frac;
endmodule

FILE: design/kfpi_lerp.sv
module kfpi_lerp import kfpi_pkg::*; (
    input  logic                        i_clk,
    input  logic signed [CoordBits-1:0] i_a,
    input  logic signed [CoordBits-1:0] i_b,
    input  logic [FracBits-1:0]         i_frac,
    output logic signed [CoordBits-1:0] o_res
);
    // three-stage shared lerp: difference, product, floor add
    logic signed [CoordBits:0]      r_diff;
    logic signed [CoordBits-1:0]    r_a1, r_a2;
    logic [FracBits-1:0]            r_f1;
    logic signed [LerpProdBits:0]   r_prod;
    logic signed [CoordBits-1:0]    r_res;
    logic signed [LerpProdBits:0]   w_prod;

    assign w_prod = r_diff * $signed({1'b0, r_f1});

    always_ff @(posedge i_clk) begin
        r_diff <= (CoordBits + 1)'(i_b) - (CoordBits + 1)'(i_a);
        r_a1   <= i_a;
        r_f1   <= i_frac;
        r_prod <= w_prod;
        r_a2   <= r_a1;
        // arithmetic shift floors toward minus infinity
        r_res  <= r_a2 + CoordBits'(r_prod >>> FracBits);
    end

    assign o_res = r_res;
endmodule

FILE: design/kfpi_checker.sv
module kfpi_checker import kfpi_pkg::*; (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [95:0]  m_axis_tdata,
    input logic [2:0]   m_axis_tuser
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("request taken while result pending");
    a_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("ready right after request");
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == ST_CLEARED || m_axis_tuser == ST_EMPTY)
        |-> m_axis_tdata == '0)
        else $error("nonzero data on clear or empty");
endmodule

bind keyframe_position_interpolator_core kfpi_checker u_chk (.*);
